// File: sv/mbrs_pkg.sv
// Shared types and constants for the Modbus RTU holding-register slave.
// No dependencies; imported by modbus_rtu_register_slave_core.
`timescale 1ns / 1ps
`default_nettype none

package mbrs_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_SLAVE_ADDRESS   = 3'd0;
	localparam logic [2:0] CFG_REGISTER_LIMIT  = 3'd1;
	localparam logic [2:0] CFG_MAX_READ_COUNT  = 3'd2;
	localparam logic [2:0] CFG_MAX_WRITE_COUNT = 3'd3;
	localparam logic [2:0] CFG_FRAME_GAP_TICKS = 3'd4;

	// Function codes
	localparam logic [7:0] FN_READ_HOLDING  = 8'h03;
	localparam logic [7:0] FN_WRITE_SINGLE  = 8'h06;
	localparam logic [7:0] FN_WRITE_MULTI   = 8'h10;
	localparam logic [7:0] FN_EXC_FLAG      = 8'h80;

	// Exception codes
	localparam logic [1:0] EXC_ILLEGAL_FUNC = 2'd1;
	localparam logic [1:0] EXC_ILLEGAL_ADDR = 2'd2;
	localparam logic [1:0] EXC_ILLEGAL_DATA = 2'd3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [4:0]  READ_CAP = 5'd29;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHK_ADDR,
		ST_CHK_DATA,
		ST_CRC,
		ST_DECIDE,
		ST_W_HI_ADDR,
		ST_W_HI_DATA,
		ST_W_LO_DATA,
		ST_EMIT_PREP,
		ST_REG_FETCH,
		ST_EMIT_BODY,
		ST_EMIT_CRC
	} state_t;

	// Response shape
	typedef enum logic [1:0] {
		MODE_EXC,
		MODE_ECHO,
		MODE_READ
	} mode_t;

	// Outcome of request decode
	typedef enum logic [2:0] {
		ACT_DROP,
		ACT_EXC,
		ACT_WR06,
		ACT_READ,
		ACT_WR16
	} act_t;

	// One bit step of the reflected CRC-16
	function automatic logic [15:0] crc_bit(input logic [15:0] c);
		crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
	endfunction

endpackage

`default_nettype wire

// File: sv/modbus_rtu_register_slave_core.sv
// Modbus RTU slave core: frame buffer, CRC check, request decode, register file.
// Depends on mbrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Received bytes are stored in a frame buffer. A tick item that ends the
// silence gap closes the frame; one that overflowed or holds under 4 bytes
// is dropped, else the block stays busy: the CRC check walks the buffer
// through one bit-serial CRC unit, and each response body byte goes through
// the same unit after any wait for the output register to drain. A function
// 16 write steps through ST_W_HI_ADDR, ST_W_HI_DATA and ST_W_LO_DATA per
// register. After reset the holding register file is cleared one entry per
// cycle before the first item is accepted. The configuration port is always
// ready and must only be written while the block is idle.
module modbus_rtu_register_slave_core #(
	parameter int unsigned BUF_DEPTH = 64,
	parameter int unsigned REG_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       kind,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      tx_byte,
	output logic            last,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	import mbrs_pkg::*;

	localparam int unsigned BW   = $clog2(BUF_DEPTH);
	localparam int unsigned LENW = $clog2(BUF_DEPTH + 1);
	localparam int unsigned AW   = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;

	// Configuration registers
	logic [7:0] slave_address_q;
	logic [6:0] register_limit_q;
	logic [4:0] max_read_count_q;
	logic [4:0] max_write_count_q;
	logic [7:0] frame_gap_ticks_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q   <= 8'd1;
			register_limit_q  <= 7'd64;
			max_read_count_q  <= 5'd29;
			max_write_count_q <= 5'd25;
			frame_gap_ticks_q <= 8'd4;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SLAVE_ADDRESS:   slave_address_q   <= cfg_data;
				CFG_REGISTER_LIMIT:  register_limit_q  <= cfg_data[6:0];
				CFG_MAX_READ_COUNT:  max_read_count_q  <= cfg_data[4:0];
				CFG_MAX_WRITE_COUNT: max_write_count_q <= cfg_data[4:0];
				CFG_FRAME_GAP_TICKS: frame_gap_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// State
	state_t state_q, state_d, ret_q;
	logic [2:0]      bit_q;
	logic [LENW-1:0] frame_len_q;
	logic            ovf_q;
	logic [7:0]      sil_q;
	logic [LENW-1:0] ptr_q;
	logic [7:0]      hdr_q [7];
	logic [7:0]      tail0_q, tail1_q;
	logic [15:0]     crc_q;
	mode_t           mode_q;
	logic [1:0]      code_q;
	logic [6:0]      body_len_q;
	logic [6:0]      k_q;
	logic [AW-1:0]   reg_ptr_q;
	logic [5:0]      wcnt_q;
	logic [7:0]      hi_q;
	logic            out_valid_q;
	logic [7:0]      tx_byte_q;
	logic            last_q;

	// Memories
	logic [7:0]  buf_mem [BUF_DEPTH];
	logic [7:0]  buf_rdata_q;
	logic [15:0] reg_mem [REG_DEPTH];
	logic [15:0] reg_rdata_q;

	logic            buf_rd_en;
	logic [BW-1:0]   buf_rd_addr;
	logic            reg_we;
	logic [AW-1:0]   reg_waddr;
	logic [15:0]     reg_wdata;
	logic            reg_re;

	// Input side
	logic in_fire, byte_fire, tick_fire, close, frame_clr;
	logic [7:0] sil_inc;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign byte_fire = in_fire && !kind;
	assign tick_fire = in_fire && kind;
	assign sil_inc   = (sil_q == 8'hFF) ? 8'hFF : sil_q + 8'd1;
	assign close     = tick_fire && ((frame_len_q != '0) || ovf_q) &&
	                   (sil_inc >= frame_gap_ticks_q);

	// Request fields
	logic [15:0] start_w, cnt_w;
	logic [16:0] lim17, end17;
	logic [4:0]  rmax;
	logic [8:0]  len9, need16;
	logic        crc_ok;
	act_t        act;
	logic [1:0]  act_code;

	assign start_w = {hdr_q[2], hdr_q[3]};
	assign cnt_w   = {hdr_q[4], hdr_q[5]};
	assign lim17   = (17'(register_limit_q) < 17'(REG_DEPTH)) ?
	                 17'(register_limit_q) : 17'(REG_DEPTH);
	assign end17   = 17'(start_w) + 17'(cnt_w);
	assign rmax    = (max_read_count_q < READ_CAP) ? max_read_count_q : READ_CAP;
	assign len9    = 9'(frame_len_q);
	assign need16  = 9'({cnt_w[4:0], 1'b0}) + 9'd9;
	assign crc_ok  = (tail1_q == crc_q[7:0]) && (tail0_q == crc_q[15:8]);

	// Decode of a closed frame
	always_comb begin
		act      = ACT_DROP;
		act_code = EXC_ILLEGAL_FUNC;
		if (crc_ok && (hdr_q[0] == slave_address_q)) begin
			if (hdr_q[1] != FN_READ_HOLDING && hdr_q[1] != FN_WRITE_SINGLE &&
			    hdr_q[1] != FN_WRITE_MULTI) begin
				act = ACT_EXC;
			end else if (len9 < 9'd8) begin
				act = ACT_DROP;
			end else if (hdr_q[1] == FN_WRITE_SINGLE) begin
				if (17'(start_w) >= lim17) begin
					act      = ACT_EXC;
					act_code = EXC_ILLEGAL_ADDR;
				end else begin
					act = ACT_WR06;
				end
			end else if (hdr_q[1] == FN_READ_HOLDING) begin
				if (cnt_w == 16'd0 || cnt_w > 16'(rmax)) begin
					act      = ACT_EXC;
					act_code = EXC_ILLEGAL_DATA;
				end else if (end17 > lim17) begin
					act      = ACT_EXC;
					act_code = EXC_ILLEGAL_ADDR;
				end else begin
					act = ACT_READ;
				end
			end else begin
				if (cnt_w == 16'd0 || cnt_w > 16'(max_write_count_q)) begin
					act      = ACT_EXC;
					act_code = EXC_ILLEGAL_DATA;
				end else if (hdr_q[6] != {cnt_w[6:0], 1'b0}) begin
					act      = ACT_EXC;
					act_code = EXC_ILLEGAL_DATA;
				end else if (end17 > lim17) begin
					act      = ACT_EXC;
					act_code = EXC_ILLEGAL_ADDR;
				end else if (len9 < need16) begin
					act = ACT_DROP;
				end else begin
					act = ACT_WR16;
				end
			end
		end
	end

	// Response byte for slot k
	logic [7:0] body_byte;
	logic [6:0] kd;
	logic       out_free;

	assign kd       = k_q - 7'd3;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		body_byte = slave_address_q;
		if (k_q != 7'd0) begin
			case (mode_q)
				MODE_EXC:  body_byte = (k_q == 7'd1) ? hdr_q[1] + FN_EXC_FLAG :
				                       {6'd0, code_q};
				MODE_ECHO: body_byte = hdr_q[k_q[2:0]];
				default: begin
					if (k_q == 7'd1)
						body_byte = FN_READ_HOLDING;
					else if (k_q == 7'd2)
						body_byte = {cnt_w[6:0], 1'b0};
					else
						body_byte = kd[0] ? reg_rdata_q[7:0] : reg_rdata_q[15:8];
				end
			endcase
		end
	end

	// Next state and memory controls
	always_comb begin
		state_d     = state_q;
		frame_clr   = 1'b0;
		buf_rd_en   = 1'b0;
		buf_rd_addr = ptr_q[BW-1:0];
		reg_we      = 1'b0;
		reg_waddr   = reg_ptr_q;
		reg_wdata   = 16'd0;
		reg_re      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				reg_we = 1'b1;
				if (reg_ptr_q == AW'(REG_DEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (close) begin
					if (ovf_q || frame_len_q < LENW'(4))
						frame_clr = 1'b1;
					else
						state_d = ST_CHK_ADDR;
				end
			end
			ST_CHK_ADDR: begin
				buf_rd_en = 1'b1;
				state_d   = ST_CHK_DATA;
			end
			ST_CHK_DATA: begin
				if ((LENW + 1)'(ptr_q) + (LENW + 1)'(2) < (LENW + 1)'(frame_len_q))
					state_d = ST_CRC;
				else if ((LENW + 1)'(ptr_q) + (LENW + 1)'(1) < (LENW + 1)'(frame_len_q))
					state_d = ST_CHK_ADDR;
				else
					state_d = ST_DECIDE;
			end
			ST_CRC: begin
				if (bit_q == 3'd7)
					state_d = ret_q;
			end
			ST_DECIDE: begin
				unique case (act)
					ACT_DROP: begin
						frame_clr = 1'b1;
						state_d   = ST_IDLE;
					end
					ACT_WR06: begin
						reg_we    = 1'b1;
						reg_waddr = start_w[AW-1:0];
						reg_wdata = cnt_w;
						state_d   = ST_EMIT_PREP;
					end
					ACT_WR16: state_d = ST_W_HI_ADDR;
					default:  state_d = ST_EMIT_PREP;
				endcase
			end
			ST_W_HI_ADDR: begin
				buf_rd_en = 1'b1;
				state_d   = ST_W_HI_DATA;
			end
			ST_W_HI_DATA: begin
				buf_rd_en = 1'b1;
				state_d   = ST_W_LO_DATA;
			end
			ST_W_LO_DATA: begin
				reg_we    = 1'b1;
				reg_wdata = {hi_q, buf_rdata_q};
				if (wcnt_q + 6'd1 == cnt_w[5:0])
					state_d = ST_EMIT_PREP;
				else
					state_d = ST_W_HI_ADDR;
			end
			ST_EMIT_PREP: begin
				if (k_q < body_len_q) begin
					if (mode_q == MODE_READ && k_q >= 7'd3 && !kd[0])
						state_d = ST_REG_FETCH;
					else
						state_d = ST_EMIT_BODY;
				end else begin
					state_d = ST_EMIT_CRC;
				end
			end
			ST_REG_FETCH: begin
				reg_re  = 1'b1;
				state_d = ST_EMIT_BODY;
			end
			ST_EMIT_BODY: begin
				if (out_free)
					state_d = ST_CRC;
			end
			ST_EMIT_CRC: begin
				if (out_free) begin
					if (k_q == body_len_q) begin
						state_d = ST_EMIT_PREP;
					end else begin
						frame_clr = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	// Frame capture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= '0;
			ovf_q       <= 1'b0;
			sil_q       <= 8'd0;
		end else if (frame_clr) begin
			frame_len_q <= '0;
			ovf_q       <= 1'b0;
			sil_q       <= 8'd0;
		end else if (byte_fire) begin
			sil_q <= 8'd0;
			if (frame_len_q < LENW'(BUF_DEPTH))
				frame_len_q <= frame_len_q + LENW'(1);
			else
				ovf_q <= 1'b1;
		end else if (tick_fire && ((frame_len_q != '0) || ovf_q)) begin
			sil_q <= sil_inc;
		end
	end

	// Frame buffer
	always_ff @(posedge clk) begin
		if (byte_fire && frame_len_q < LENW'(BUF_DEPTH))
			buf_mem[frame_len_q[BW-1:0]] <= rx_byte;
		if (buf_rd_en)
			buf_rdata_q <= buf_mem[buf_rd_addr];
	end

	// Holding register file
	always_ff @(posedge clk) begin
		if (reg_we)
			reg_mem[reg_waddr] <= reg_wdata;
		if (reg_re)
			reg_rdata_q <= reg_mem[reg_ptr_q];
	end

	// Sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_ptr_q <= '0;
			bit_q     <= 3'd0;
			ret_q     <= ST_IDLE;
		end else begin
			case (state_q)
				ST_CLEAR: reg_ptr_q <= reg_ptr_q + AW'(1);
				ST_IDLE: begin
					ptr_q <= '0;
					crc_q <= CRC_INIT;
				end
				ST_CHK_DATA: begin
					if (ptr_q < LENW'(7))
						hdr_q[ptr_q[2:0]] <= buf_rdata_q;
					tail1_q <= tail0_q;
					tail0_q <= buf_rdata_q;
					ptr_q   <= ptr_q + LENW'(1);
					bit_q   <= 3'd0;
					ret_q   <= ((LENW + 1)'(ptr_q) + (LENW + 1)'(1) <
					            (LENW + 1)'(frame_len_q)) ? ST_CHK_ADDR : ST_DECIDE;
					if ((LENW + 1)'(ptr_q) + (LENW + 1)'(2) < (LENW + 1)'(frame_len_q))
						crc_q <= crc_q ^ {8'd0, buf_rdata_q};
				end
				ST_CRC: begin
					crc_q <= crc_bit(crc_q);
					bit_q <= bit_q + 3'd1;
				end
				ST_DECIDE: begin
					crc_q     <= CRC_INIT;
					k_q       <= 7'd0;
					code_q    <= act_code;
					reg_ptr_q <= start_w[AW-1:0];
					ptr_q     <= LENW'(7);
					wcnt_q    <= 6'd0;
					if (act == ACT_READ) begin
						mode_q     <= MODE_READ;
						body_len_q <= 7'd3 + {cnt_w[5:0], 1'b0};
					end else if (act == ACT_EXC) begin
						mode_q     <= MODE_EXC;
						body_len_q <= 7'd3;
					end else begin
						mode_q     <= MODE_ECHO;
						body_len_q <= 7'd6;
					end
				end
				ST_W_HI_ADDR: ptr_q <= ptr_q + LENW'(1);
				ST_W_HI_DATA: begin
					hi_q  <= buf_rdata_q;
					ptr_q <= ptr_q + LENW'(1);
				end
				ST_W_LO_DATA: begin
					reg_ptr_q <= reg_ptr_q + AW'(1);
					wcnt_q    <= wcnt_q + 6'd1;
				end
				ST_REG_FETCH: reg_ptr_q <= reg_ptr_q + AW'(1);
				ST_EMIT_BODY: begin
					if (out_free) begin
						crc_q <= crc_q ^ {8'd0, body_byte};
						k_q   <= k_q + 7'd1;
						bit_q <= 3'd0;
						ret_q <= ST_EMIT_PREP;
					end
				end
				ST_EMIT_CRC: begin
					if (out_free)
						k_q <= k_q + 7'd1;
				end
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free && (state_q == ST_EMIT_BODY || state_q == ST_EMIT_CRC)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_EMIT_BODY) begin
			tx_byte_q <= body_byte;
			last_q    <= 1'b0;
		end else if (out_free && state_q == ST_EMIT_CRC) begin
			tx_byte_q <= (k_q == body_len_q) ? crc_q[7:0] : crc_q[15:8];
			last_q    <= (k_q != body_len_q);
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte   = tx_byte_q;
	assign last      = last_q;

endmodule

`default_nettype wire
